@@ rtl/core/warmup_moving_average_filter_top_defines.svh @@
// ----------------------------------------------------------------------------
// warmup moving average filter: assertion macros
// shared concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef WARMUP_MOVING_AVERAGE_FILTER_TOP_DEFINES_SVH
`define WARMUP_MOVING_AVERAGE_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define WMAF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wmaf assertion failed");
// checked on every edge, reset included
`define WMAF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("wmaf assertion failed");
`else
`define WMAF_ASSERT(label, clk, rst_n, prop)
`define WMAF_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ rtl/core/wmaf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmaf_pkg
// types and fixed constants of the moving average filter
// ----------------------------------------------------------------------------
package wmaf_pkg;

    localparam int SAMPLE_W = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV
    } t_state;

endpackage

@@ rtl/core/wmaf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmaf_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module wmaf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/wmaf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmaf_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "warmup_moving_average_filter_top_defines.svh"

module wmaf_div #(
    parameter int DVD_W = 21,
    parameter int DVS_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] n_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVD_W-1:0] n_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] n_dvs;

    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_fit;

    // shift the next dividend bit into the partial remainder
    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    always_comb begin
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_quo = r_quo;
        n_dvs = r_dvs;
        if (i_start) begin
            n_cnt = CNT_W'(DVD_W);
            n_rem = '0;
            n_quo = i_dividend;
            n_dvs = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CNT_W'(1);
            n_rem = w_fit ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], w_fit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

    `WMAF_ASSERT(a_start_when_free, i_clk, i_rst_n, i_start |-> r_cnt == '0)
    `WMAF_ASSERT(a_step_countdown, i_clk, i_rst_n, r_cnt != '0 |=> r_cnt == $past(r_cnt) - CNT_W'(1))

endmodule

@@ rtl/core/warmup_moving_average_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// warmup_moving_average_filter_top
// moving average over the last DEPTH millivolt samples, warm-up aware
// ----------------------------------------------------------------------------
// One averaged sample comes out per sample taken in. The last DEPTH samples
// sit in a ring ram; a running total is kept and the mean is that total over
// the number of samples seen so far, capped at DEPTH, truncated. One item is
// worked on at a time: the ring slot is read, the total updated and written
// back, then a restoring divider produces one quotient bit per cycle across
// the 16 + clog2(DEPTH+1) bit total. No new sample is taken until the divider
// is done and its quotient has moved to the output register, which waits for
// a stalled earlier result to leave. The result sits in that register, so the
// next sample is taken while it waits. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "warmup_moving_average_filter_top_defines.svh"

module warmup_moving_average_filter_top #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_sample_mv,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_average_mv
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = wmaf_pkg::SAMPLE_W + CW;

    wmaf_pkg::t_state r_state;
    wmaf_pkg::t_state n_state;

    logic [PW-1:0] r_wr_pos;
    logic [PW-1:0] n_wr_pos;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [SW-1:0] r_total;
    logic [SW-1:0] n_total;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [wmaf_pkg::SAMPLE_W-1:0] r_sample;
    logic [wmaf_pkg::SAMPLE_W-1:0] r_average;
    logic [wmaf_pkg::SAMPLE_W-1:0] n_average;

    logic                          w_in_accept;
    logic                          w_full;
    logic                          w_slot_free;
    logic                          w_div_start;
    logic                          w_div_busy;
    logic [SW-1:0]                 w_quotient;
    logic [wmaf_pkg::SAMPLE_W-1:0] w_old_sample;
    logic [SW-1:0]                 w_old_term;
    logic [SW-1:0]                 w_upd_total;
    logic [CW-1:0]                 w_upd_count;
    logic [PW-1:0]                 w_upd_pos;

    assign o_in_stall  = (r_state != wmaf_pkg::ST_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_div_start = (r_state == wmaf_pkg::ST_READ);

    // the oldest sample only leaves the total once the ring has filled
    assign w_old_term  = w_full ? SW'(w_old_sample) : '0;
    assign w_upd_total = r_total - w_old_term + SW'(r_sample);
    assign w_upd_count = w_full ? r_count : r_count + CW'(1);
    assign w_upd_pos   = (r_wr_pos == PW'(DEPTH - 1)) ? '0 : r_wr_pos + PW'(1);

    // read at acceptance, write back in the next cycle; the fsm admits no second
    // beat in between, so the same slot is never in flight twice
    wmaf_ram #(
        .WIDTH (wmaf_pkg::SAMPLE_W),
        .DEPTH (DEPTH),
        .ADDR_W(PW)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (w_div_start),
        .i_waddr(r_wr_pos),
        .i_wdata(r_sample),
        .i_re   (w_in_accept),
        .i_raddr(r_wr_pos),
        .o_rdata(w_old_sample)
    );

    wmaf_div #(
        .DVD_W(SW),
        .DVS_W(CW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(w_upd_total),
        .i_divisor (w_upd_count),
        .o_busy    (w_div_busy),
        .o_quotient(w_quotient)
    );

    always_comb begin
        n_state     = r_state;
        n_wr_pos    = r_wr_pos;
        n_count     = r_count;
        n_total     = r_total;
        n_out_valid = r_out_valid && i_out_stall;
        n_average   = r_average;
        case (r_state)
            wmaf_pkg::ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = wmaf_pkg::ST_READ;
                end
            end
            wmaf_pkg::ST_READ: begin
                n_wr_pos = w_upd_pos;
                n_count  = w_upd_count;
                n_total  = w_upd_total;
                n_state  = wmaf_pkg::ST_DIV;
            end
            wmaf_pkg::ST_DIV: begin
                if (!w_div_busy && w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_average   = w_quotient[wmaf_pkg::SAMPLE_W-1:0];
                    n_state     = wmaf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wmaf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wmaf_pkg::ST_IDLE;
            r_wr_pos    <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_pos    <= n_wr_pos;
            r_count     <= n_count;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_sample <= i_sample_mv;
        end
        r_average <= n_average;
    end

    assign o_out_valid  = r_out_valid;
    assign o_average_mv = r_average;

    `WMAF_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `WMAF_ASSERT(a_empty_total, i_clk, i_rst_n, r_count == '0 |-> r_total == '0)
    `WMAF_ASSERT(a_accept_read, i_clk, i_rst_n, w_in_accept |=> r_state == wmaf_pkg::ST_READ)
    `WMAF_ASSERT(a_result_from_div, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_state) == wmaf_pkg::ST_DIV)
    `WMAF_ASSERT_ALWAYS(a_reset_clean, i_clk, !i_rst_n |=> !o_out_valid && r_count == '0)

endmodule

@@ tb/warmup_moving_average_filter_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// warmup_moving_average_filter_top_test
// self-checking bench: millivolt samples go in over a valid/stall channel, a
// running copy of the averaging ring predicts every averaged beat, and each
// beat that leaves the block is compared against the oldest prediction
// ----------------------------------------------------------------------------
module warmup_moving_average_filter_top_test;

    localparam int SAMPLE_W        = wmaf_pkg::SAMPLE_W;
    localparam int AVG_DEPTH       = 16;
    localparam int SLOT_W          = $clog2(AVG_DEPTH);
    localparam int TOTAL_W         = SAMPLE_W + $clog2(AVG_DEPTH + 1);
    localparam int IDLE_PCT        = 23;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 60;
    localparam int CYCLE_LIMIT     = 400000;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [SAMPLE_W-1:0] i_sample_mv;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [SAMPLE_W-1:0] o_average_mv;

    // running copy of the filter state
    logic [SAMPLE_W-1:0] held_samples [AVG_DEPTH];
    logic [SLOT_W-1:0]   next_slot    = '0;
    bit                  ring_filled  = 1'b0;
    logic [TOTAL_W-1:0]  held_total   = '0;

    logic [SAMPLE_W-1:0] expected_avg [$];
    int                  mismatches   = 0;
    int                  cycle_count  = 0;
    bit                  idling       = 1'b1;
    int                  hold_requests = 0;
    int                  hold_seen;
    int                  hold_left;

    warmup_moving_average_filter_top #(
        .DEPTH (AVG_DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_mv  (i_sample_mv),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_average_mv (o_average_mv)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // offers one sample, waits for the beat, then updates the predicted average
    task automatic send_sample(input logic [SAMPLE_W-1:0] mv);
        logic [TOTAL_W-1:0] held_count;
        while (idling && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_mv <= mv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);

        // the oldest slot drops out only once the ring has wrapped
        if (ring_filled) held_total = held_total - held_samples[next_slot];
        held_samples[next_slot] = mv;
        held_total = held_total + mv;
        if (next_slot == SLOT_W'(AVG_DEPTH - 1)) begin
            next_slot   = '0;
            ring_filled = 1'b1;
        end else begin
            next_slot = next_slot + 1'b1;
        end
        held_count = ring_filled ? TOTAL_W'(AVG_DEPTH) : TOTAL_W'(next_slot);
        expected_avg.push_back(SAMPLE_W'(held_total / held_count));
    endtask

    // mostly full-range, some rail values, the rest jitter round a slow level
    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] level);
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return SAMPLE_W'($urandom_range(65535));
        else if (roll < 70) return roll[0] ? '1 : '0;
        else return level + SAMPLE_W'($urandom_range(63)) - SAMPLE_W'(32);
    endfunction

    // receiving side: random stalls, or a long counted hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_seen   <= 0;
            hold_left   <= 0;
        end else if (hold_requests != hold_seen) begin
            hold_seen   <= hold_requests;
            hold_left   <= HOLD_OFF_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idling && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        logic [SAMPLE_W-1:0] due_avg;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_avg.size() == 0) begin
                $display("%0t: average beat with none pending, expected none, actual %0d",
                         $time, o_average_mv);
                mismatches++;
            end else begin
                due_avg = expected_avg.pop_front();
                if (o_average_mv !== due_avg) begin
                    $display("%0t: average_mv mismatch, expected %0d, actual %0d",
                             $time, due_avg, o_average_mv);
                    mismatches++;
                end
            end
        end
    end

    // first sample comes straight through, then the divisor grows with the fill
    task automatic test_warmup_fill();
        send_sample('1);
        send_sample('0);
        send_sample(16'd1);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        repeat (AVG_DEPTH - 5) send_sample('1);
    endtask

    // write position wraps; the five pushed-out slots leave a ring of all ones, then two mid-range values go in
    task automatic test_slot_replacement();
        repeat (5) send_sample('1);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
    endtask

    task automatic test_back_to_back();
        idling = 1'b0;
        repeat (60) send_sample(pick_sample(16'd3300));
        idling = 1'b1;
    endtask

    task automatic test_output_hold_off();
        hold_requests <= hold_requests + 1;
        repeat (20) send_sample(pick_sample(16'd12000));
    endtask

    task automatic test_random_stream();
        logic [SAMPLE_W-1:0] level;
        level = 16'd3700;
        for (int n = 0; n < 650; n++) begin
            if (n % 50 == 0) level = SAMPLE_W'($urandom_range(65535));
            send_sample(pick_sample(level));
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample_mv = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_warmup_fill();
        test_slot_replacement();
        test_back_to_back();
        test_output_hold_off();
        test_random_stream();
        i_in_valid <= 1'b0;

        while (expected_avg.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ warmup_moving_average_filter_top.f @@
+incdir+rtl/core
rtl/core/wmaf_pkg.sv
rtl/core/wmaf_ram.sv
rtl/core/wmaf_div.sv
rtl/core/warmup_moving_average_filter_top.sv
tb/warmup_moving_average_filter_top_test.sv
